### rtl/core/obr_pkg.sv
// Shared types and constants for the OHLCV bar resampler.
`default_nettype none
package obr_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned PriceW = 32;
  localparam int unsigned VolInW = 32;
  localparam int unsigned VolW   = 48;
  localparam int unsigned IvlW   = 17;
  localparam int unsigned SymW   = 6;
  localparam logic [IvlW-1:0] IvlReset = 17'd60;

  // Input bar as it travels from the front part to the back part.
  typedef struct packed {
    logic [SymW-1:0]   sym;
    logic [TimeW-1:0]  t;
    logic [PriceW-1:0] o;
    logic [PriceW-1:0] h;
    logic [PriceW-1:0] l;
    logic [PriceW-1:0] c;
    logic [VolInW-1:0] v;
  } bar_t;

  // Finished candle.
  typedef struct packed {
    logic [SymW-1:0]   sym;
    logic [TimeW-1:0]  start;
    logic [PriceW-1:0] o;
    logic [PriceW-1:0] h;
    logic [PriceW-1:0] l;
    logic [PriceW-1:0] c;
    logic [VolW-1:0]   v;
  } candle_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DIV,
    ST_WRITE,
    ST_EMIT
  } be_state_t;

endpackage
`default_nettype wire

### rtl/core/ohlcv_bar_resampler.sv
// Top level of the OHLCV bar resampler.
// Sequencer: READ registers the stored candle, CHECK examines it, WRITE
// stores the update; a symbol's first bar also passes DIV (one remainder
// bit per cycle). A new bar is taken only once the last one is written.
// Reset: synchronous active-low; clears started flags, queue and output;
// the interval register returns to 60 seconds.
`default_nettype none
module ohlcv_bar_resampler
  import obr_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 64
) (
  input  wire  logic         clk,
  input  wire  logic         rst_n,
  input  wire  logic         cfg_we,
  input  wire  logic [16:0]  cfg_wdata,
  input  wire  logic         in_tvalid,
  output logic               in_tready,
  // symbol_index[5:0], bar_time[37:6], bar_open, bar_high, bar_low,
  // bar_close, bar_volume[197:166], zero fill to 200.
  input  wire  logic [199:0] in_tdata,
  output logic               out_tvalid,
  input  wire  logic         out_tready,
  // candle_symbol[5:0], candle_start, candle_open, candle_high, candle_low,
  // candle_close, candle_volume[213:166], zero fill to 216.
  output logic [215:0]       out_tdata
);

  logic [IvlW-1:0] ivl_r;
  bar_t    in_bar, q_bar;
  candle_t cand;
  logic    q_valid, q_ready;

  // Interval register.
  always_ff @(posedge clk) begin
    if (!rst_n) ivl_r <= IvlReset;
    else if (cfg_we) ivl_r <= cfg_wdata;
  end

  assign in_bar = '{sym: in_tdata[5:0], t: in_tdata[37:6], o: in_tdata[69:38],
                    h: in_tdata[101:70], l: in_tdata[133:102],
                    c: in_tdata[165:134], v: in_tdata[197:166]};
  assign out_tdata = {2'b00, cand.v, cand.c, cand.l, cand.h, cand.o,
                      cand.start, cand.sym};

  obr_front #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_bar,
    .q_valid, .q_ready, .q_bar
  );

  obr_back #(.SYMBOL_COUNT(SYMBOL_COUNT)) u_back (
    .clk, .rst_n, .ivl(ivl_r), .q_valid, .q_ready, .q_bar,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_candle(cand)
  );

endmodule
`default_nettype wire

### rtl/core/obr_front.sv
// Front part: accepts bars, drops out-of-range symbols and queues the rest.
`default_nettype none
module obr_front
  import obr_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 64
) (
  input  wire  logic clk,
  input  wire  logic rst_n,
  input  wire  logic in_valid,
  output logic       in_ready,
  input  wire  bar_t in_bar,
  output logic       q_valid,
  input  wire  logic q_ready,
  output bar_t       q_bar
);

  // Two-entry queue.
  bar_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop, in_range;

  assign in_range = ({26'd0, in_bar.sym} < 32'(SYMBOL_COUNT));
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready && in_range;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_bar    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_bar;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 2'd1))
    else $error("queue count not advanced on push");

endmodule
`default_nettype wire

### rtl/core/obr_back.sv
// Back part: per-symbol read-modify-write of the running candle.
`default_nettype none
module obr_back
  import obr_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = 64
) (
  input  wire  logic            clk,
  input  wire  logic            rst_n,
  input  wire  logic [IvlW-1:0] ivl,
  input  wire  logic            q_valid,
  output logic                  q_ready,
  input  wire  bar_t            q_bar,
  output logic                  out_valid,
  input  wire  logic            out_ready,
  output candle_t               out_candle
);

  localparam int unsigned AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  typedef struct packed {
    logic [TimeW-1:0]  start;
    logic [PriceW-1:0] o;
    logic [PriceW-1:0] h;
    logic [PriceW-1:0] l;
    logic [PriceW-1:0] c;
    logic [VolW-1:0]   v;
  } run_t;

  // Candle store and started flags.
  run_t                    mem_r [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] started_r;
  run_t                    rd_r;

  be_state_t state_r, state_nxt;
  bar_t      bar_r;
  logic [AW-1:0] addr;
  logic          st_r;
  logic [TimeW-1:0] rem_r, rem_nxt;
  logic [5:0]       bit_r, bit_nxt;
  logic [IvlW-1:0]  len;
  logic [TimeW:0]   end_t;
  logic             close_now;
  run_t             wr;
  logic             wr_en, take, emit_fire;
  candle_t          cand_r, cand_nxt;
  logic             ov_r, ov_nxt;
  logic [VolW:0]    vsum;
  logic [TimeW:0]   rem_sh;

  assign addr  = bar_r.sym[AW-1:0];
  assign len   = (ivl == '0) ? IvlW'(1) : ivl;
  assign end_t = {1'b0, rd_r.start} + {{(TimeW+1-IvlW){1'b0}}, len};
  assign close_now = ({1'b0, bar_r.t} >= end_t);
  assign vsum = {1'b0, rd_r.v} + {{(VolW+1-VolInW){1'b0}}, bar_r.v};
  assign take = (state_r == ST_IDLE) && q_valid;
  assign q_ready = (state_r == ST_IDLE);
  assign out_valid = ov_r;
  assign out_candle = cand_r;
  assign emit_fire = ov_r && out_ready;
  // Restoring remainder, one bit a cycle, MSB first.
  assign rem_sh = {rem_r, bar_r.t[bit_r[4:0]]};

  // Next state. The stored entry is registered in READ and examined in CHECK.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (!st_r) state_nxt = ST_DIV;
        else if (close_now && ov_r) state_nxt = ST_EMIT;
        else state_nxt = ST_WRITE;
      end
      ST_DIV:   if (bit_r == 6'd0) state_nxt = ST_WRITE;
      ST_EMIT:  if (!ov_r || out_ready) state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    wr_en    = 1'b0;
    wr       = rd_r;
    cand_nxt = cand_r;
    ov_nxt   = emit_fire ? 1'b0 : ov_r;
    case (state_r)
      ST_IDLE: begin
        rem_nxt = '0;
        bit_nxt = 6'd31;
      end
      ST_DIV: begin
        if (rem_sh >= {{(TimeW+1-IvlW){1'b0}}, len}) begin
          rem_nxt = TimeW'(rem_sh - {{(TimeW+1-IvlW){1'b0}}, len});
        end else begin
          rem_nxt = rem_sh[TimeW-1:0];
        end
        bit_nxt = bit_r - 6'd1;
      end
      ST_WRITE: begin
        wr_en = 1'b1;
        if (!st_r || close_now) begin
          wr.o = bar_r.o;
          wr.h = bar_r.h;
          wr.l = bar_r.l;
          wr.c = bar_r.c;
          wr.v = {{(VolW-VolInW){1'b0}}, bar_r.v};
          wr.start = !st_r ? (bar_r.t - rem_r) : end_t[TimeW-1:0];
        end else begin
          if (bar_r.h > rd_r.h) wr.h = bar_r.h;
          if (bar_r.l < rd_r.l) wr.l = bar_r.l;
          wr.c = bar_r.c;
          wr.v = vsum[VolW] ? {VolW{1'b1}} : vsum[VolW-1:0];
        end
        if (st_r && close_now) begin
          ov_nxt   = 1'b1;
          cand_nxt = '{sym: bar_r.sym, start: rd_r.start, o: rd_r.o, h: rd_r.h,
                       l: rd_r.l, c: rd_r.c, v: rd_r.v};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (wr_en) started_r[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) bar_r <= q_bar;
    if (state_r == ST_READ) begin
      rd_r <= mem_r[addr];
      st_r <= started_r[addr];
    end
    if (wr_en) mem_r[addr] <= wr;
    rem_r  <= rem_nxt;
    bit_r  <= bit_nxt;
    cand_r <= cand_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |=> ov_r)
    else $error("candle dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE && st_r && close_now) |-> (!ov_r || out_ready))
    else $error("candle overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WRITE) |=> started_r[$past(addr)])
    else $error("started flag not set");

endmodule
`default_nettype wire
